// File: src/rsps_pkg.sv
// Shared constants and register codes for the ray/sphere pixel shader.
package rsps_pkg;

  localparam int COORD_BITS_DEFAULT = 12;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int SIZE_BITS      = 13;
  localparam int RADIUS_BITS    = 16;
  localparam int COLOR_BITS     = 8;
  localparam int FRAC_BITS      = 14;
  localparam int COORD_Q_BITS   = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_SPHERE_RADIUS = 3'd2,
    REG_SPHERE_RED    = 3'd3,
    REG_SPHERE_GREEN  = 3'd4,
    REG_SPHERE_BLUE   = 3'd5
  } cfg_reg_t;

  localparam logic [SIZE_BITS-1:0]   RST_IMAGE_WIDTH   = 13'd1024;
  localparam logic [SIZE_BITS-1:0]   RST_IMAGE_HEIGHT  = 13'd768;
  localparam logic [RADIUS_BITS-1:0] RST_SPHERE_RADIUS = 16'd8192;
  localparam logic [COLOR_BITS-1:0]  RST_SPHERE_RED    = 8'd255;
  localparam logic [COLOR_BITS-1:0]  RST_SPHERE_GREEN  = 8'd0;
  localparam logic [COLOR_BITS-1:0]  RST_SPHERE_BLUE   = 8'd255;

  localparam logic [14:0] FRAC_ONE     = 15'd16384;
  localparam logic [14:0] SQRT3_Q14    = 15'd28378;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

endpackage

// File: src/rsps_udiv.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
module rsps_udiv #(
  parameter int N_BITS = 32,
  parameter int D_BITS = 16,
  parameter int Q_BITS = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_BITS-1:0] dividend,
  input  logic [D_BITS-1:0] divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_BITS-1:0] quotient,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);

  localparam int W = (N_BITS > D_BITS + Q_BITS) ? N_BITS : D_BITS + Q_BITS;

  logic [Q_BITS:0]   vld;
  logic [Q_BITS:0]   ovs;
  logic [W-1:0]      rem      [0:Q_BITS];
  logic [W-1:0]      rem_next [0:Q_BITS];
  logic [D_BITS-1:0] dvs      [0:Q_BITS];
  logic [Q_BITS-1:0] quo      [0:Q_BITS];
  logic [Q_BITS-1:0] quo_next [0:Q_BITS];
  logic [SIDE_W-1:0] side     [0:Q_BITS];
  logic              ovf_in;

  assign ovf_in = W'(dividend) >= (W'(divisor) << Q_BITS);

  always_comb begin
    logic [W-1:0] trial;
    trial = '0;
    rem_next[0] = rem[0];
    quo_next[0] = quo[0];
    for (int k = 1; k <= Q_BITS; k++) begin
      trial = W'(dvs[k-1]) << (Q_BITS - k);
      if (rem[k-1] >= trial) begin
        rem_next[k] = rem[k-1] - trial;
        quo_next[k] = quo[k-1] | (Q_BITS'(1) << (Q_BITS - k));
      end else begin
        rem_next[k] = rem[k-1];
        quo_next[k] = quo[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_BITS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= W'(dividend);
      dvs[0]  <= divisor;
      quo[0]  <= '0;
      side[0] <= side_in;
      ovs     <= {ovs[Q_BITS-1:0], ovf_in};
      for (int k = 1; k <= Q_BITS; k++) begin
        rem[k]  <= rem_next[k];
        dvs[k]  <= dvs[k-1];
        quo[k]  <= quo_next[k];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[Q_BITS];
  assign quotient  = quo[Q_BITS];
  assign ovf       = ovs[Q_BITS];
  assign side_out  = side[Q_BITS];

endmodule

// File: src/rsps_isqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
module rsps_isqrt #(
  parameter int R_BITS = 16,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*R_BITS-1:0] radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [R_BITS-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  logic [R_BITS:0]       vld;
  logic [2*R_BITS-1:0]   vv      [0:R_BITS];
  logic [R_BITS:0]       rm      [0:R_BITS];
  logic [R_BITS:0]       rm_next [0:R_BITS];
  logic [R_BITS-1:0]     rt      [0:R_BITS];
  logic [R_BITS-1:0]     rt_next [0:R_BITS];
  logic [SIDE_W-1:0]     side    [0:R_BITS];

  always_comb begin
    logic [R_BITS+2:0] remw;
    logic [R_BITS+2:0] trial;
    logic [R_BITS+2:0] diff;
    remw  = '0;
    trial = '0;
    diff  = '0;
    rm_next[0] = rm[0];
    rt_next[0] = rt[0];
    for (int k = 1; k <= R_BITS; k++) begin
      remw  = {rm[k-1], vv[k-1][2*R_BITS-1 -: 2]};
      trial = {1'b0, rt[k-1], 2'b01};
      diff  = remw - trial;
      if (remw >= trial) begin
        rm_next[k] = diff[R_BITS:0];
        rt_next[k] = {rt[k-1][R_BITS-2:0], 1'b1};
      end else begin
        rm_next[k] = remw[R_BITS:0];
        rt_next[k] = {rt[k-1][R_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[R_BITS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vv[0]   <= radicand;
      rm[0]   <= '0;
      rt[0]   <= '0;
      side[0] <= side_in;
      for (int k = 1; k <= R_BITS; k++) begin
        vv[k]   <= vv[k-1] << 2;
        rm[k]   <= rm_next[k];
        rt[k]   <= rt_next[k];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[R_BITS];
  assign root      = rt[R_BITS];
  assign side_out  = side[R_BITS];

endmodule

// File: src/ray_sphere_pixel_shader.sv
// Ray/sphere intersection with Lambert shading, one pixel per clock.
// Throughput: one pixel per cycle; the pipeline holds every stage while out_stall
// blocks a waiting result, and in_stall follows that hold.
// Reset (rst, synchronous): clears all stage valid bits and loads register defaults.
module ray_sphere_pixel_shader #(
  parameter int COORD_BITS = rsps_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [rsps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rsps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [COORD_BITS-1:0]                pixel_x,
  input  logic [COORD_BITS-1:0]                pixel_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [31:0]                          rgba_word,
  output logic                                 ray_hit
);

  localparam int MAG_BITS  = (COORD_BITS + 1 > rsps_pkg::SIZE_BITS) ? COORD_BITS + 1
                                                                    : rsps_pkg::SIZE_BITS;
  localparam int DIFF_BITS = MAG_BITS + 1;
  localparam int CDIV_N    = MAG_BITS + rsps_pkg::FRAC_BITS;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [17:0]        a14;
    logic               hit;
  } sq1_side_t;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic               hit;
    logic               neg;
  } tdv_side_t;

  typedef struct packed {
    logic signed [21:0] sum;
    logic               hit;
  } sq2_side_t;

  typedef struct packed {
    logic pos;
    logic hit;
  } idv_side_t;

  localparam logic signed [53:0] E_ONE = 54'sd4398046511104;
  localparam logic [24:0]        T_ONE = 25'd2097152;

  function automatic logic signed [15:0] sat_coord(input logic [15:0] q, input logic ov,
                                                    input logic neg);
    logic signed [15:0] res;
    if (!neg) begin
      res = (ov || q[15]) ? 16'sh7FFF : $signed(q);
    end else begin
      res = (ov || q > 16'h8000) ? 16'sh8000 : $signed(-q);
    end
    return res;
  endfunction

  // configuration registers
  logic [rsps_pkg::SIZE_BITS-1:0]   image_width;
  logic [rsps_pkg::SIZE_BITS-1:0]   image_height;
  logic [rsps_pkg::RADIUS_BITS-1:0] sphere_radius;
  logic [rsps_pkg::COLOR_BITS-1:0]  sphere_red;
  logic [rsps_pkg::COLOR_BITS-1:0]  sphere_green;
  logic [rsps_pkg::COLOR_BITS-1:0]  sphere_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= rsps_pkg::RST_IMAGE_WIDTH;
      image_height  <= rsps_pkg::RST_IMAGE_HEIGHT;
      sphere_radius <= rsps_pkg::RST_SPHERE_RADIUS;
      sphere_red    <= rsps_pkg::RST_SPHERE_RED;
      sphere_green  <= rsps_pkg::RST_SPHERE_GREEN;
      sphere_blue   <= rsps_pkg::RST_SPHERE_BLUE;
    end else if (cfg_write_en) begin
      case (rsps_pkg::cfg_reg_t'(cfg_index))
        rsps_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[12:0];
        rsps_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[12:0];
        rsps_pkg::REG_SPHERE_RADIUS: sphere_radius <= cfg_data;
        rsps_pkg::REG_SPHERE_RED:    sphere_red    <= cfg_data[7:0];
        rsps_pkg::REG_SPHERE_GREEN:  sphere_green  <= cfg_data[7:0];
        rsps_pkg::REG_SPHERE_BLUE:   sphere_blue   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [rsps_pkg::SIZE_BITS-1:0] h_eff;
  logic [31:0]                    r2;
  logic signed [33:0]             c28;

  assign h_eff = (image_height == '0) ? 13'd1 : image_height;
  assign r2    = sphere_radius * sphere_radius;

  always_ff @(posedge clk) begin
    c28 <= 34'sd268435456 - $signed({2'b00, r2});
  end

  // global advance
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage A: pixel offsets
  logic signed [DIFF_BITS-1:0] dx, dy;
  logic                        v_a;
  logic [MAG_BITS-1:0]         a_magx, a_magy;
  logic                        a_negx, a_negy;

  assign dx = $signed(DIFF_BITS'({pixel_x, 1'b0})) - $signed(DIFF_BITS'(image_width));
  assign dy = $signed(DIFF_BITS'({pixel_y, 1'b0})) - $signed(DIFF_BITS'(h_eff));

  always_ff @(posedge clk) begin
    if (adv) begin
      a_negx <= dx[DIFF_BITS-1];
      a_negy <= dy[DIFF_BITS-1];
      a_magx <= dx[DIFF_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
      a_magy <= dy[DIFF_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
    end
  end

  // coordinate dividers
  logic        dx_valid, dy_valid, dx_ovf, dy_ovf, dx_neg, dy_neg;
  logic [15:0] dx_q, dy_q;

  rsps_udiv #(
    .N_BITS(CDIV_N), .D_BITS(rsps_pkg::SIZE_BITS), .Q_BITS(rsps_pkg::COORD_Q_BITS), .SIDE_W(1)
  ) u_div_x (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_a),
    .dividend({a_magx, 14'd0}), .divisor(h_eff), .side_in(a_negx),
    .out_valid(dx_valid), .quotient(dx_q), .ovf(dx_ovf), .side_out(dx_neg)
  );

  rsps_udiv #(
    .N_BITS(CDIV_N), .D_BITS(rsps_pkg::SIZE_BITS), .Q_BITS(rsps_pkg::COORD_Q_BITS), .SIDE_W(1)
  ) u_div_y (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_a),
    .dividend({a_magy, 14'd0}), .divisor(h_eff), .side_in(a_negy),
    .out_valid(dy_valid), .quotient(dy_q), .ovf(dy_ovf), .side_out(dy_neg)
  );

  // stages C, M1..M4: discriminant
  logic               v_c, v_m1, v_m2, v_m3, v_m4;
  logic signed [15:0] c_cx, c_cy, m1_cx, m1_cy, m2_cx, m2_cy, m3_cx, m3_cy, m4_cx, m4_cy;
  logic [31:0]        m1_xx, m1_yy;
  logic [31:0]        a28;
  logic [17:0]        m2_a14, m3_a14, m4_a14;
  logic signed [52:0] m3_prod;
  logic signed [53:0] e42;
  logic               m4_hit;
  logic [49:0]        m4_rad;

  assign a28 = m1_xx + m1_yy + 32'd268435456;
  assign e42 = E_ONE - 54'(m3_prod);

  always_ff @(posedge clk) begin
    if (adv) begin
      c_cx    <= sat_coord(dx_q, dx_ovf, dx_neg);
      c_cy    <= sat_coord(dy_q, dy_ovf, dy_neg);
      m1_cx   <= c_cx;
      m1_cy   <= c_cy;
      m1_xx   <= c_cx * c_cx;
      m1_yy   <= c_cy * c_cy;
      m2_cx   <= m1_cx;
      m2_cy   <= m1_cy;
      m2_a14  <= a28[31:14];
      m3_cx   <= m2_cx;
      m3_cy   <= m2_cy;
      m3_a14  <= m2_a14;
      m3_prod <= $signed({1'b0, m2_a14}) * c28;
      m4_cx   <= m3_cx;
      m4_cy   <= m3_cy;
      m4_a14  <= m3_a14;
      m4_hit  <= !e42[53];
      m4_rad  <= e42[53] ? 50'd0 : e42[49:0];
    end
  end

  // root of the discriminant
  sq1_side_t   sq1_in, sq1_out;
  logic        sq1_valid;
  logic [24:0] s21;

  assign sq1_in = '{cx: m4_cx, cy: m4_cy, a14: m4_a14, hit: m4_hit};

  rsps_isqrt #(.R_BITS(25), .SIDE_W($bits(sq1_side_t))) u_sqrt_disc (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_m4), .radicand(m4_rad),
    .side_in(sq1_in), .out_valid(sq1_valid), .root(s21), .side_out(sq1_out)
  );

  // stage T0: numerator of the near root
  logic        v_t0;
  logic [31:0] t0_num;
  logic [17:0] t0_a14;
  tdv_side_t   t0_side;
  logic        t_neg;
  logic [24:0] t_mag;

  assign t_neg = s21 > T_ONE;
  assign t_mag = t_neg ? s21 - T_ONE : T_ONE - s21;

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_num  <= {t_mag, 7'd0};
      t0_a14  <= sq1_out.a14;
      t0_side <= '{cx: sq1_out.cx, cy: sq1_out.cy, hit: sq1_out.hit, neg: t_neg};
    end
  end

  tdv_side_t   td_side;
  logic        td_valid, td_ovf;
  logic [17:0] td_q;

  rsps_udiv #(.N_BITS(32), .D_BITS(18), .Q_BITS(18), .SIDE_W($bits(tdv_side_t))) u_div_t (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_t0),
    .dividend(t0_num), .divisor(t0_a14), .side_in(t0_side),
    .out_valid(td_valid), .quotient(td_q), .ovf(td_ovf), .side_out(td_side)
  );

  // stages H1..H5: hit point and its length squared
  logic               v_h1, v_h2, v_h3, v_h4, v_h5;
  logic signed [18:0] h1_t14;
  logic signed [15:0] h1_cx, h1_cy;
  logic               h1_hit, h2_hit, h3_hit, h4_hit, h5_hit;
  logic signed [34:0] h2_px, h2_py, pxa, pya;
  logic signed [19:0] h2_hz, h3_hx, h3_hy, h3_hz;
  logic signed [39:0] sxx, syy, szz;
  logic [39:0]        h4_xx, h4_yy, h4_zz;
  logic signed [21:0] h4_sum, h5_sum;
  logic [39:0]        h5_ss;

  assign pxa = h2_px + (h2_px[34] ? 35'sd16383 : 35'sd0);
  assign pya = h2_py + (h2_py[34] ? 35'sd16383 : 35'sd0);
  assign sxx = h3_hx * h3_hx;
  assign syy = h3_hy * h3_hy;
  assign szz = h3_hz * h3_hz;

  always_ff @(posedge clk) begin
    if (adv) begin
      h1_t14 <= td_side.neg ? -$signed({1'b0, td_q}) : $signed({1'b0, td_q});
      h1_cx  <= td_side.cx;
      h1_cy  <= td_side.cy;
      h1_hit <= td_side.hit;
      h2_px  <= h1_t14 * h1_cx;
      h2_py  <= h1_t14 * h1_cy;
      h2_hz  <= 20'sd16384 - 20'(h1_t14);
      h2_hit <= h1_hit;
      h3_hx  <= $signed(pxa[33:14]);
      h3_hy  <= $signed(pya[33:14]);
      h3_hz  <= h2_hz;
      h3_hit <= h2_hit;
      h4_xx  <= sxx[39:0];
      h4_yy  <= syy[39:0];
      h4_zz  <= szz[39:0];
      h4_sum <= 22'(h3_hx) + 22'(h3_hy) + 22'(h3_hz);
      h4_hit <= h3_hit;
      h5_ss  <= h4_xx + h4_yy + h4_zz;
      h5_sum <= h4_sum;
      h5_hit <= h4_hit;
    end
  end

  sq2_side_t   sq2_in, sq2_out;
  logic        sq2_valid;
  logic [19:0] len;

  assign sq2_in = '{sum: h5_sum, hit: h5_hit};

  rsps_isqrt #(.R_BITS(20), .SIDE_W($bits(sq2_side_t))) u_sqrt_len (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_h5), .radicand(h5_ss),
    .side_in(sq2_in), .out_valid(sq2_valid), .root(len), .side_out(sq2_out)
  );

  // stage L1: intensity division operands
  logic        v_l1;
  logic [48:0] l1_num;
  logic [34:0] l1_den;
  idv_side_t   l1_side;
  logic        l_pos;

  assign l_pos = !sq2_out.sum[21] && (sq2_out.sum != '0) && (len != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_num  <= l_pos ? {sq2_out.sum[20:0], 28'd0} : 49'd0;
      l1_den  <= len * rsps_pkg::SQRT3_Q14;
      l1_side <= '{pos: l_pos, hit: sq2_out.hit};
    end
  end

  idv_side_t   id_side;
  logic        id_valid, id_ovf;
  logic [14:0] id_q;

  rsps_udiv #(.N_BITS(49), .D_BITS(35), .Q_BITS(15), .SIDE_W($bits(idv_side_t))) u_div_i (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_l1),
    .dividend(l1_num), .divisor(l1_den), .side_in(l1_side),
    .out_valid(id_valid), .quotient(id_q), .ovf(id_ovf), .side_out(id_side)
  );

  // stage F1: clamped intensity, F2: color output
  logic        v_f1, f1_hit;
  logic [14:0] f1_i14;
  logic [22:0] pr, pg, pb;

  assign pr = sphere_red * f1_i14;
  assign pg = sphere_green * f1_i14;
  assign pb = sphere_blue * f1_i14;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!id_side.pos) begin
        f1_i14 <= '0;
      end else if (id_ovf || id_q > rsps_pkg::FRAC_ONE) begin
        f1_i14 <= rsps_pkg::FRAC_ONE;
      end else begin
        f1_i14 <= id_q;
      end
      f1_hit  <= id_side.hit;
      ray_hit <= f1_hit;
      if (f1_hit) begin
        rgba_word <= {rsps_pkg::ALPHA_OPAQUE, pb[21:14], pg[21:14], pr[21:14]};
      end else begin
        rgba_word <= {rsps_pkg::ALPHA_OPAQUE, 24'd0};
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_c       <= 1'b0;
      v_m1      <= 1'b0;
      v_m2      <= 1'b0;
      v_m3      <= 1'b0;
      v_m4      <= 1'b0;
      v_t0      <= 1'b0;
      v_h1      <= 1'b0;
      v_h2      <= 1'b0;
      v_h3      <= 1'b0;
      v_h4      <= 1'b0;
      v_h5      <= 1'b0;
      v_l1      <= 1'b0;
      v_f1      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_a       <= in_valid;
      v_c       <= dx_valid;
      v_m1      <= v_c;
      v_m2      <= v_m1;
      v_m3      <= v_m2;
      v_m4      <= v_m3;
      v_t0      <= sq1_valid;
      v_h1      <= td_valid;
      v_h2      <= v_h1;
      v_h3      <= v_h2;
      v_h4      <= v_h3;
      v_h5      <= v_h4;
      v_l1      <= sq2_valid;
      v_f1      <= id_valid;
      out_valid <= v_f1;
    end
  end

  a_div_lanes: assert property (@(posedge clk) disable iff (rst) dx_valid == dy_valid)
    else $error("coordinate divider lanes out of step");

  a_t_range: assert property (@(posedge clk) disable iff (rst) td_valid |-> !td_ovf)
    else $error("near root quotient out of range");

  a_i14_range: assert property (@(posedge clk) disable iff (rst)
    v_f1 |-> f1_i14 <= rsps_pkg::FRAC_ONE)
    else $error("intensity above one");

endmodule

// File: tb/sv/ray_sphere_pixel_shader_checker.sv
// Checker for the ray/sphere pixel shader: shading prediction and result compare.
`timescale 1ns / 100ps
module ray_sphere_pixel_shader_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [rsps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rsps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] rgba_word,
  input  logic        ray_hit,
  output int          fail_count,
  output int          pending,
  output int          hits_seen,
  output int          misses_seen
);

  typedef struct packed {
    logic [31:0] rgba;
    logic        hit;
  } pixel_result_t;

  logic [rsps_pkg::SIZE_BITS-1:0]   width_q, height_q;
  logic [rsps_pkg::RADIUS_BITS-1:0] radius_q;
  logic [rsps_pkg::COLOR_BITS-1:0]  red_q, green_q, blue_q;
  pixel_result_t                    shade_queue[$];

  assign pending = shade_queue.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint norm_coord(longint p, longint span, longint h);
    longint q;
    q = ((2 * p - span) * 16384) / h;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic pixel_result_t shade_pixel(logic [11:0] px, logic [11:0] py);
    pixel_result_t res;
    longint h, r, cx, cy, a14, c28, e42, s21, t14, hx, hy, hz, sum, i14, len;
    longint unsigned red, green, blue;
    h = (height_q != 0) ? longint'(height_q) : 1;
    r = longint'(radius_q);
    cx = norm_coord(longint'(px), longint'(width_q), h);
    cy = norm_coord(longint'(py), h, h);
    a14 = (cx * cx + cy * cy + (64'sd1 << 28)) >>> 14;
    c28 = (64'sd1 << 28) - r * r;
    e42 = (64'sd1 << 42) - a14 * c28;
    i14 = 0;
    if (e42 < 0) begin
      res.rgba = 32'hFF000000;
      res.hit = 1'b0;
      return res;
    end
    s21 = longint'(int_sqrt(longint'(e42)));
    t14 = ((64'sd1 << 21) - s21) * 128 / a14;
    hx = t14 * cx / 16384;
    hy = t14 * cy / 16384;
    hz = 16384 - t14;
    sum = hx + hy + hz;
    if (sum > 0) begin
      len = longint'(int_sqrt(hx * hx + hy * hy + hz * hz));
      if (len > 0) begin
        i14 = sum * (64'sd1 << 28) / (len * 28378);
        if (i14 > 16384) i14 = 16384;
      end
    end
    red = (longint'(red_q) * i14) >> 14;
    green = (longint'(green_q) * i14) >> 14;
    blue = (longint'(blue_q) * i14) >> 14;
    if (red > 255) red = 255;
    if (green > 255) green = 255;
    if (blue > 255) blue = 255;
    res.rgba = {rsps_pkg::ALPHA_OPAQUE, blue[7:0], green[7:0], red[7:0]};
    res.hit = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      fail_count = 0;
      hits_seen = 0;
      misses_seen = 0;
      width_q <= rsps_pkg::RST_IMAGE_WIDTH;
      height_q <= rsps_pkg::RST_IMAGE_HEIGHT;
      radius_q <= rsps_pkg::RST_SPHERE_RADIUS;
      red_q <= rsps_pkg::RST_SPHERE_RED;
      green_q <= rsps_pkg::RST_SPHERE_GREEN;
      blue_q <= rsps_pkg::RST_SPHERE_BLUE;
    end else begin
      if (out_valid && !out_stall) begin
        if (shade_queue.size() == 0) begin
          report_mismatch("unexpected transfer", rgba_word, 0);
        end else begin
          want = shade_queue.pop_front();
          if (rgba_word !== want.rgba) report_mismatch("rgba_word", rgba_word, want.rgba);
          if (ray_hit !== want.hit) report_mismatch("ray_hit", ray_hit, want.hit);
          if (want.hit) hits_seen++;
          else misses_seen++;
        end
      end
      if (in_valid && !in_stall) shade_queue.push_back(shade_pixel(pixel_x, pixel_y));
      if (cfg_write_en) begin
        case (cfg_index)
          rsps_pkg::REG_IMAGE_WIDTH:   width_q <= cfg_data[rsps_pkg::SIZE_BITS-1:0];
          rsps_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_data[rsps_pkg::SIZE_BITS-1:0];
          rsps_pkg::REG_SPHERE_RADIUS: radius_q <= cfg_data;
          rsps_pkg::REG_SPHERE_RED:    red_q <= cfg_data[7:0];
          rsps_pkg::REG_SPHERE_GREEN:  green_q <= cfg_data[7:0];
          rsps_pkg::REG_SPHERE_BLUE:   blue_q <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/sv/ray_sphere_pixel_shader_tb.sv
// Testbench top for the ray/sphere pixel shader: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module ray_sphere_pixel_shader_tb;

  localparam int LATENCY = 114;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst;
  logic cfg_write_en;
  logic [rsps_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [rsps_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic in_valid, in_stall, out_valid, out_stall, ray_hit;
  logic [11:0] pixel_x, pixel_y;
  logic [31:0] rgba_word;
  int fail_count, pending, hits_seen, misses_seen;
  int cycle_count;
  bit long_hold;
  logic [12:0] cur_w, cur_h;

  ray_sphere_pixel_shader u_dut (.*);

  ray_sphere_pixel_shader_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("ray_sphere_pixel_shader_tb: done, errors");
        $finish;
      end
    end
  end

  // receiver: random stall per transfer, plus one long hold
  initial begin
    int gap;
    bit held;
    held = 0;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold && !held) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        held = 1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic write_reg(rsps_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    if (idx == rsps_pkg::REG_IMAGE_WIDTH) cur_w = val[12:0];
    if (idx == rsps_pkg::REG_IMAGE_HEIGHT) cur_h = val[12:0];
  endtask

  task automatic drain_pipe();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= px;
    pixel_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    pixel_x <= 12'($urandom);
    pixel_y <= 12'($urandom);
  endtask

  task automatic random_pixels(int count);
    bit burst;
    logic [11:0] px, py;
    for (int i = 0; i < count; i++) begin
      burst = (i % 200) < 40;
      if ($urandom_range(0, 9) == 0) begin
        px = 12'($urandom);
        py = 12'($urandom);
      end else begin
        px = 12'($urandom_range(0, (cur_w > 4096 || cur_w == 0) ? 4095 : cur_w - 1));
        py = 12'($urandom_range(0, (cur_h > 4096 || cur_h == 0) ? 4095 : cur_h - 1));
      end
      send_pixel(px, py, burst);
    end
    idle_input();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel_x = '0;
    pixel_y = '0;
    long_hold = 0;
    cur_w = 13'd1024;
    cur_h = 13'd768;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: reset settings, corners, centre, out-of-frame
    send_pixel(0, 0, 0);
    send_pixel(512, 384, 0);
    send_pixel(1023, 767, 0);
    send_pixel(12'hFFF, 12'hFFF, 0);
    send_pixel(12'hFFF, 0, 0);
    send_pixel(400, 300, 0);
    send_pixel(600, 450, 0);
    idle_input();
    drain_pipe();

    // zero radius, zero height, width one
    write_reg(rsps_pkg::REG_SPHERE_RADIUS, 16'd0);
    write_reg(rsps_pkg::REG_IMAGE_HEIGHT, 16'd0);
    write_reg(rsps_pkg::REG_IMAGE_WIDTH, 16'd1);
    write_reg(rsps_pkg::REG_SPHERE_GREEN, 16'd255);
    send_pixel(0, 0, 0);
    send_pixel(1, 1, 0);
    send_pixel(12'hFFF, 12'hABC, 0);
    idle_input();
    drain_pipe();

    // camera inside sphere, maximum radius, 4096 by 4096 frame
    write_reg(rsps_pkg::REG_SPHERE_RADIUS, 16'hFFFF);
    write_reg(rsps_pkg::REG_IMAGE_WIDTH, 16'd4096);
    write_reg(rsps_pkg::REG_IMAGE_HEIGHT, 16'd4096);
    write_reg(rsps_pkg::REG_SPHERE_RED, 16'd0);
    write_reg(rsps_pkg::REG_SPHERE_BLUE, 16'd128);
    send_pixel(0, 0, 0);
    send_pixel(2048, 2048, 0);
    send_pixel(4095, 4095, 0);
    send_pixel(3000, 1000, 0);
    idle_input();
    drain_pipe();

    // square frame, full radius one, with a long output hold
    write_reg(rsps_pkg::REG_IMAGE_WIDTH, 16'd64);
    write_reg(rsps_pkg::REG_IMAGE_HEIGHT, 16'd64);
    write_reg(rsps_pkg::REG_SPHERE_RADIUS, 16'd16384);
    write_reg(rsps_pkg::REG_SPHERE_RED, 16'd255);
    write_reg(rsps_pkg::REG_SPHERE_GREEN, 16'd200);
    write_reg(rsps_pkg::REG_SPHERE_BLUE, 16'd255);
    long_hold = 1;
    random_pixels(500);
    drain_pipe();

    // random settings phases
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(rsps_pkg::REG_IMAGE_WIDTH, 16'($urandom_range(1, 8191)));
      write_reg(rsps_pkg::REG_IMAGE_HEIGHT, 16'($urandom_range(0, 8191)));
      write_reg(rsps_pkg::REG_SPHERE_RADIUS,
                (ph % 2) ? 16'($urandom) : 16'($urandom_range(4000, 20000)));
      write_reg(rsps_pkg::REG_SPHERE_RED, 16'($urandom_range(0, 255)));
      write_reg(rsps_pkg::REG_SPHERE_GREEN, 16'($urandom_range(0, 255)));
      write_reg(rsps_pkg::REG_SPHERE_BLUE, 16'($urandom_range(0, 255)));
      random_pixels(300);
      drain_pipe();
    end

    $display("covered reset, edge and random settings; %0d hits, %0d misses",
             hits_seen, misses_seen);
    if (fail_count == 0) begin
      $display("ray_sphere_pixel_shader_tb: done, clean");
    end else begin
      $display("ray_sphere_pixel_shader_tb: done, errors");
    end
    $finish;
  end

endmodule
